// ===== hw/rtl/functional_graph_distance_query_top_macros.svh =====
// Assertion macros used by the checker file.
// FGDQ_ASSERT: clocked property, masked while reset is asserted.
// FGDQ_ASSERT_RST: clocked property that also holds across reset.
`ifndef FUNCTIONAL_GRAPH_DISTANCE_QUERY_TOP_MACROS_SVH
`define FUNCTIONAL_GRAPH_DISTANCE_QUERY_TOP_MACROS_SVH

`define FGDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define FGDQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fgdq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fgdq_pkg
// Shared constants for the functional graph distance query block.
// ---------------------------------------------------------------------------
package fgdq_pkg;

    localparam int DEF_NODES       = 1024;
    localparam int DEF_LIFT_LEVELS = 10;

    localparam int PORT_NODE_W = 10;   // node_a / node_b field width
    localparam int CNT_W       = 11;   // node_count register width
    localparam int DIST_W      = 10;   // distance field width
    localparam int REQ_W       = 2;    // req_type field width
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

endpackage

// ===== hw/rtl/fgdq_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fgdq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module fgdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/functional_graph_distance_query_top.sv =====
`timescale 1ns / 1ps
// A query is either rejected early or answered from the node labels, with a lift
// walk through the jump memory when needed, one level per pass. Build and query
// timing is set by the single read port of each table memory. One item at a time.
// Reset is synchronous: control state and the built flag are cleared and
// node_count is set to 1024; table memories are not cleared (every entry a query
// reads is written by a build).
// ---------------------------------------------------------------------------
// functional_graph_distance_query_top
// Binary-lifting distance queries on a functional graph, run by one sequencer
// over single-port-read table memories.
// ---------------------------------------------------------------------------
module functional_graph_distance_query_top
    import fgdq_pkg::*;
#(
    parameter int NODES       = DEF_NODES,
    parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CNT_W-1:0]       i_cfg_wdata,      // node_count
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [9:0] node_a, [19:10] node_b
    input  logic [REQ_W-1:0]       i_s_axis_tuser,   // [1:0] req_type
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // [0] reachable, [10:1] distance
);

    localparam int NW  = $clog2(NODES);
    localparam int CW  = $clog2(NODES + 1);
    localparam int LW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int LCW = $clog2(LIFT_LEVELS + 1);
    localparam int AW  = LW + NW;
    localparam int GW  = CW + 1;

    localparam logic [4:0] S_IDLE  = 5'd0,  S_CLR   = 5'd1,  S_SRD   = 5'd2,
                           S_SIN   = 5'd3,  S_SWR   = 5'd4,  S_LRD   = 5'd5,
                           S_LX    = 5'd6,  S_LWR   = 5'd7,  S_PRD   = 5'd8,
                           S_PCHK  = 5'd9,  S_QHD   = 5'd10, S_QU    = 5'd11,
                           S_QV    = 5'd12, S_QDEC  = 5'd13, S_CRD   = 5'd14,
                           S_CCHK  = 5'd15, S_WRD   = 5'd16, S_WCHK  = 5'd17,
                           S_WNXT  = 5'd18, S_URD   = 5'd19, S_UU    = 5'd20,
                           S_UV    = 5'd21, S_UWR   = 5'd22, S_QA    = 5'd23,
                           S_QB    = 5'd24, S_LIFT  = 5'd25, S_LIFTD = 5'd26,
                           S_GRD   = 5'd27, S_GAP   = 5'd28, S_DONE  = 5'd29;

    function automatic logic [AW-1:0] jaddr(input logic [LCW-1:0] lv,
                                            input logic [NW-1:0] idx);
        jaddr = {lv[LW-1:0], idx};
    endfunction

    // control registers
    logic [4:0]       r_state, n_state;
    logic             r_built, n_built;
    logic [CNT_W-1:0] r_nc, n_nc;
    logic             r_out_valid, n_out_valid;

    // sequencer working registers
    logic [CW-1:0]     r_i, n_i, r_head, n_head, r_tail, n_tail, r_pos, n_pos;
    logic [CW-1:0]     r_len, n_len;
    logic [LCW-1:0]    r_lv, n_lv;
    logic [NW-1:0]     r_comp, n_comp, r_cur, n_cur, r_s, n_s, r_v, n_v, r_u, n_u;
    logic [NW-1:0]     r_a, n_a, r_b, n_b, r_ca, n_ca, r_da, n_da, r_pa, n_pa;
    logic [NW-1:0]     r_pb, n_pb, r_x, n_x, r_steps, n_steps, r_extra, n_extra;
    logic [NW-1:0]     r_pfrom, n_pfrom;
    logic              r_va, n_va, r_root, n_root, r_ok, n_ok;
    logic [DIST_W-1:0] r_dist, n_dist, r_out_dist, n_out_dist;
    logic              r_out_ok, n_out_ok;

    // memory ports
    logic                   succ_we;
    logic [NW-1:0]          succ_waddr, succ_raddr;
    logic [PORT_NODE_W-1:0] succ_wdata, succ_rdata;
    logic                   jump_we;
    logic [AW-1:0]          jump_waddr, jump_raddr;
    logic [NW-1:0]          jump_wdata, jump_rdata;
    logic                   deg_we;
    logic [NW-1:0]          deg_waddr, deg_raddr;
    logic [CW-1:0]          deg_wdata, deg_rdata;
    logic                   que_we;
    logic [NW-1:0]          que_waddr, que_raddr, que_wdata, que_rdata;
    logic                   comp_we;
    logic [NW-1:0]          comp_waddr, comp_raddr, comp_wdata, comp_rdata;
    logic                   pos_we;
    logic [NW-1:0]          pos_waddr, pos_raddr, pos_wdata, pos_rdata;
    logic                   vld_we;
    logic [NW-1:0]          vld_waddr, vld_raddr;
    logic                   vld_wdata, vld_rdata;
    logic                   dep_we;
    logic [NW-1:0]          dep_waddr, dep_raddr, dep_wdata, dep_rdata;
    logic                   clen_we;
    logic [NW-1:0]          clen_waddr, clen_raddr;
    logic [CW-1:0]          clen_wdata, clen_rdata;

    // input fields
    logic [PORT_NODE_W-1:0] w_in_a, w_in_b;
    logic                   w_accept;
    assign w_in_a   = i_s_axis_tdata[PORT_NODE_W-1:0];
    assign w_in_b   = i_s_axis_tdata[2*PORT_NODE_W-1:PORT_NODE_W];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // active node count, clamped to 1..NODES
    logic [31:0]   w_nc32;
    logic [CW-1:0] w_n, w_nlast;
    assign w_nc32  = 32'(r_nc);
    assign w_n     = (w_nc32 == 32'd0) ? CW'(1) :
                     (w_nc32 > 32'(NODES)) ? CW'(NODES) : CW'(w_nc32);
    assign w_nlast = w_n - CW'(1);

    // cycle gap: (pos_to + len - pos_from) mod len, operand below twice len
    logic [GW-1:0] w_sum, w_gap;
    assign w_sum = GW'(r_pb) + GW'(r_len) - GW'(r_pfrom);
    assign w_gap = (r_len == '0) ? '0 :
                   (w_sum >= GW'(r_len)) ? (w_sum - GW'(r_len)) : w_sum;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - DIST_W - 1)'(0), r_out_dist, r_out_ok};

    // sequencer
    always_comb begin
        n_state = r_state; n_built = r_built; n_nc = r_nc;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_ok = r_out_ok; n_out_dist = r_out_dist;
        n_i = r_i; n_head = r_head; n_tail = r_tail; n_pos = r_pos; n_len = r_len;
        n_lv = r_lv; n_comp = r_comp; n_cur = r_cur; n_s = r_s; n_v = r_v; n_u = r_u;
        n_a = r_a; n_b = r_b; n_ca = r_ca; n_da = r_da; n_pa = r_pa; n_pb = r_pb;
        n_x = r_x; n_steps = r_steps; n_extra = r_extra; n_pfrom = r_pfrom;
        n_va = r_va; n_root = r_root; n_ok = r_ok; n_dist = r_dist;

        succ_we = 1'b0; succ_waddr = NW'(w_in_a); succ_wdata = w_in_b;
        succ_raddr = r_i[NW-1:0];
        jump_we = 1'b0; jump_waddr = '0; jump_wdata = '0; jump_raddr = '0;
        deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0; deg_raddr = r_i[NW-1:0];
        que_we = 1'b0; que_waddr = r_tail[NW-1:0]; que_wdata = '0; que_raddr = '0;
        comp_we = 1'b0; comp_waddr = '0; comp_wdata = '0; comp_raddr = '0;
        pos_we = 1'b0; pos_waddr = '0; pos_wdata = '0; pos_raddr = '0;
        vld_we = 1'b0; vld_waddr = '0; vld_wdata = 1'b0; vld_raddr = r_i[NW-1:0];
        dep_we = 1'b0; dep_waddr = '0; dep_wdata = '0; dep_raddr = '0;
        clen_we = 1'b0; clen_waddr = r_comp; clen_wdata = r_pos; clen_raddr = r_ca;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority case (i_s_axis_tuser)
                        REQ_LOAD: begin
                            if (32'(w_in_a) < 32'(NODES)) begin
                                succ_we = 1'b1;
                                n_built = 1'b0;
                            end
                        end
                        REQ_BUILD: begin
                            n_i = '0;
                            n_state = S_CLR;
                        end
                        REQ_QUERY: begin
                            if (!r_built || 32'(w_in_a) >= 32'(w_n) ||
                                32'(w_in_b) >= 32'(w_n)) begin
                                n_ok = 1'b0;
                                n_dist = '0;
                                n_state = S_DONE;
                            end else begin
                                n_a = NW'(w_in_a);
                                n_b = NW'(w_in_b);
                                comp_raddr = NW'(w_in_a);
                                vld_raddr = NW'(w_in_a);
                                dep_raddr = NW'(w_in_a);
                                pos_raddr = NW'(w_in_a);
                                n_state = S_QA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (i_cfg_we) begin
                    n_nc = i_cfg_wdata;
                    n_built = 1'b0;
                end
            end
            // clear per-node state of the active range
            S_CLR: begin
                deg_we = 1'b1; deg_waddr = r_i[NW-1:0];
                vld_we = 1'b1; vld_waddr = r_i[NW-1:0];
                dep_we = 1'b1; dep_waddr = r_i[NW-1:0];
                if (r_i == w_nlast) begin
                    n_i = '0;
                    n_state = S_SRD;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            // level 0 of the jump table and in-degree counts
            S_SRD: n_state = S_SIN;
            S_SIN: begin
                n_s = (32'(succ_rdata) >= 32'(w_n)) ? '0 : NW'(succ_rdata);
                jump_we = 1'b1;
                jump_waddr = jaddr('0, r_i[NW-1:0]);
                jump_wdata = n_s;
                deg_raddr = n_s;
                n_state = S_SWR;
            end
            S_SWR: begin
                deg_we = 1'b1; deg_waddr = r_s; deg_wdata = deg_rdata + CW'(1);
                if (r_i == w_nlast) begin
                    n_i = '0;
                    n_tail = '0;
                    if (LIFT_LEVELS > 1) begin
                        n_lv = LCW'(1);
                        n_state = S_LRD;
                    end else begin
                        n_state = S_PRD;
                    end
                end else begin
                    n_i = r_i + CW'(1);
                    n_state = S_SRD;
                end
            end
            // higher jump levels
            S_LRD: begin
                jump_raddr = jaddr(r_lv - LCW'(1), r_i[NW-1:0]);
                n_state = S_LX;
            end
            S_LX: begin
                jump_raddr = jaddr(r_lv - LCW'(1), jump_rdata);
                n_state = S_LWR;
            end
            S_LWR: begin
                jump_we = 1'b1;
                jump_waddr = jaddr(r_lv, r_i[NW-1:0]);
                jump_wdata = jump_rdata;
                n_state = S_LRD;
                if (r_i == w_nlast) begin
                    n_i = '0;
                    if (32'(r_lv) == 32'(LIFT_LEVELS - 1)) begin
                        n_tail = '0;
                        n_state = S_PRD;
                    end else begin
                        n_lv = r_lv + LCW'(1);
                    end
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            // seed the peel queue with leaves
            S_PRD: n_state = S_PCHK;
            S_PCHK: begin
                if (deg_rdata == '0) begin
                    que_we = 1'b1; que_wdata = r_i[NW-1:0];
                    n_tail = r_tail + CW'(1);
                end
                if (r_i == w_nlast) begin
                    n_head = '0;
                    n_state = S_QHD;
                end else begin
                    n_i = r_i + CW'(1);
                    n_state = S_PRD;
                end
            end
            // peel tree nodes
            S_QHD: begin
                que_raddr = r_head[NW-1:0];
                if (r_head == r_tail) begin
                    n_i = '0;
                    n_comp = '0;
                    n_state = S_CRD;
                end else begin
                    n_state = S_QU;
                end
            end
            S_QU: begin
                jump_raddr = jaddr('0, que_rdata);
                n_head = r_head + CW'(1);
                n_state = S_QV;
            end
            S_QV: begin
                n_v = jump_rdata;
                deg_raddr = jump_rdata;
                n_state = S_QDEC;
            end
            S_QDEC: begin
                deg_we = 1'b1; deg_waddr = r_v; deg_wdata = deg_rdata - CW'(1);
                if (deg_wdata == '0 && r_tail < w_n) begin
                    que_we = 1'b1; que_wdata = r_v;
                    n_tail = r_tail + CW'(1);
                end
                n_state = S_QHD;
            end
            // label the remaining cycles
            S_CRD: n_state = S_CCHK;
            S_CCHK: begin
                if (deg_rdata != '0 && !vld_rdata) begin
                    n_cur = r_i[NW-1:0];
                    n_pos = '0;
                    n_state = S_WRD;
                end else if (r_i == w_nlast) begin
                    n_state = S_URD;
                end else begin
                    n_i = r_i + CW'(1);
                    n_state = S_CRD;
                end
            end
            S_WRD: begin
                vld_raddr = r_cur;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if (!vld_rdata && r_pos < w_n) begin
                    vld_we = 1'b1; vld_waddr = r_cur; vld_wdata = 1'b1;
                    pos_we = 1'b1; pos_waddr = r_cur; pos_wdata = NW'(r_pos);
                    comp_we = 1'b1; comp_waddr = r_cur; comp_wdata = r_comp;
                    n_pos = r_pos + CW'(1);
                    jump_raddr = jaddr('0, r_cur);
                    n_state = S_WNXT;
                end else begin
                    clen_we = 1'b1;
                    if (32'(r_comp) + 32'd1 < 32'(w_n)) begin
                        n_comp = r_comp + NW'(1);
                    end
                    if (r_i == w_nlast) begin
                        n_state = S_URD;
                    end else begin
                        n_i = r_i + CW'(1);
                        n_state = S_CRD;
                    end
                end
            end
            S_WNXT: begin
                n_cur = jump_rdata;
                n_state = S_WRD;
            end
            // unwind the queue: depth and label from the successor
            S_URD: begin
                que_raddr = r_tail[NW-1:0] - NW'(1);
                if (r_tail == '0) begin
                    n_built = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_tail = r_tail - CW'(1);
                    n_state = S_UU;
                end
            end
            S_UU: begin
                n_u = que_rdata;
                jump_raddr = jaddr('0, que_rdata);
                n_state = S_UV;
            end
            S_UV: begin
                dep_raddr = jump_rdata;
                comp_raddr = jump_rdata;
                n_state = S_UWR;
            end
            S_UWR: begin
                dep_we = 1'b1; dep_waddr = r_u; dep_wdata = dep_rdata + NW'(1);
                comp_we = 1'b1; comp_waddr = r_u; comp_wdata = comp_rdata;
                n_state = S_URD;
            end
            // query: start node labels, then target labels
            S_QA: begin
                n_ca = comp_rdata; n_va = vld_rdata; n_da = dep_rdata; n_pa = pos_rdata;
                comp_raddr = r_b; vld_raddr = r_b; dep_raddr = r_b; pos_raddr = r_b;
                n_state = S_QB;
            end
            S_QB: begin
                n_pb = pos_rdata;
                n_x = r_a;
                n_lv = '0;
                n_ok = 1'b0;
                n_dist = '0;
                n_state = S_DONE;
                if (r_ca != comp_rdata) begin
                    n_ok = 1'b0;
                end else if (vld_rdata) begin
                    if (r_va) begin
                        n_root = 1'b0;
                        n_pfrom = r_pa;
                        n_extra = '0;
                        n_state = S_GRD;
                    end else begin
                        n_root = 1'b1;
                        n_steps = r_da;
                        n_extra = r_da;
                        n_state = S_LIFT;
                    end
                end else if (!r_va && r_da >= dep_rdata) begin
                    n_root = 1'b0;
                    n_steps = r_da - dep_rdata;
                    n_extra = r_da - dep_rdata;
                    n_state = S_LIFT;
                end
            end
            // lift walk, one level per pass
            S_LIFT: begin
                jump_raddr = jaddr(r_lv, r_x);
                pos_raddr = r_x;
                if (32'(r_lv) == 32'(LIFT_LEVELS)) begin
                    if (r_root) begin
                        n_state = S_GRD;
                    end else begin
                        n_ok = (r_x == r_b);
                        n_dist = (r_x == r_b) ? DIST_W'(r_extra) : '0;
                        n_state = S_DONE;
                    end
                end else if (r_steps[0]) begin
                    n_state = S_LIFTD;
                end else begin
                    n_lv = r_lv + LCW'(1);
                    n_steps = r_steps >> 1;
                end
            end
            S_LIFTD: begin
                n_x = jump_rdata;
                n_lv = r_lv + LCW'(1);
                n_steps = r_steps >> 1;
                n_state = S_LIFT;
            end
            S_GRD: n_state = S_GAP;
            S_GAP: begin
                n_ok = 1'b1;
                n_dist = DIST_W'(GW'(r_extra) + w_gap);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_ok = r_ok;
                    n_out_dist = r_ok ? r_dist : '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // gap operands land in the cycle after the read
        if (r_state == S_GRD) begin
            n_len = clen_rdata;
            n_pfrom = r_root ? pos_rdata : r_pa;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_built <= 1'b0;
            r_nc <= NODE_COUNT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_built <= n_built;
            r_nc <= n_nc;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_head <= n_head; r_tail <= n_tail; r_pos <= n_pos; r_len <= n_len;
        r_lv <= n_lv; r_comp <= n_comp; r_cur <= n_cur; r_s <= n_s; r_v <= n_v;
        r_u <= n_u; r_a <= n_a; r_b <= n_b; r_ca <= n_ca; r_da <= n_da; r_pa <= n_pa;
        r_pb <= n_pb; r_x <= n_x; r_steps <= n_steps; r_extra <= n_extra;
        r_pfrom <= n_pfrom; r_va <= n_va; r_root <= n_root; r_ok <= n_ok;
        r_dist <= n_dist; r_out_ok <= n_out_ok; r_out_dist <= n_out_dist;
    end

    // table memories
    fgdq_ram #(.WIDTH(PORT_NODE_W), .DEPTH(NODES)) u_succ (
        .i_clk(i_clk), .i_we(succ_we), .i_waddr(succ_waddr), .i_wdata(succ_wdata),
        .i_raddr(succ_raddr), .o_rdata(succ_rdata));
    fgdq_ram #(.WIDTH(NW), .DEPTH(2 ** AW)) u_jump (
        .i_clk(i_clk), .i_we(jump_we), .i_waddr(jump_waddr), .i_wdata(jump_wdata),
        .i_raddr(jump_raddr), .o_rdata(jump_rdata));
    fgdq_ram #(.WIDTH(CW), .DEPTH(NODES)) u_deg (
        .i_clk(i_clk), .i_we(deg_we), .i_waddr(deg_waddr), .i_wdata(deg_wdata),
        .i_raddr(deg_raddr), .o_rdata(deg_rdata));
    fgdq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_que (
        .i_clk(i_clk), .i_we(que_we), .i_waddr(que_waddr), .i_wdata(que_wdata),
        .i_raddr(que_raddr), .o_rdata(que_rdata));
    fgdq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_comp (
        .i_clk(i_clk), .i_we(comp_we), .i_waddr(comp_waddr), .i_wdata(comp_wdata),
        .i_raddr(comp_raddr), .o_rdata(comp_rdata));
    fgdq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pos_raddr), .o_rdata(pos_rdata));
    fgdq_ram #(.WIDTH(1), .DEPTH(NODES)) u_vld (
        .i_clk(i_clk), .i_we(vld_we), .i_waddr(vld_waddr), .i_wdata(vld_wdata),
        .i_raddr(vld_raddr), .o_rdata(vld_rdata));
    fgdq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_dep (
        .i_clk(i_clk), .i_we(dep_we), .i_waddr(dep_waddr), .i_wdata(dep_wdata),
        .i_raddr(dep_raddr), .o_rdata(dep_rdata));
    fgdq_ram #(.WIDTH(CW), .DEPTH(NODES)) u_clen (
        .i_clk(i_clk), .i_we(clen_we), .i_waddr(clen_waddr), .i_wdata(clen_wdata),
        .i_raddr(clen_raddr), .o_rdata(clen_rdata));

endmodule

// ===== hw/rtl/fgdq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fgdq_checker
// Port-level checks on the distance query block, bound to the top level.
// ---------------------------------------------------------------------------
`include "functional_graph_distance_query_top_macros.svh"

module fgdq_checker
    import fgdq_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_we,
    input logic [CNT_W-1:0]       i_cfg_wdata,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic [REQ_W-1:0]       i_s_axis_tuser,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // a result beat is held until taken
    `FGDQ_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result beat dropped")

    // unreachable answers carry zero distance
    `FGDQ_ASSERT(a_unreach_zero, o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[10:1] == 10'd0, "nonzero distance on unreachable")

    // a query beat keeps the sequencer busy, so ready drops once it is accepted
    `FGDQ_ASSERT(a_query_busy, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == REQ_QUERY |=> !o_s_axis_tready, "ready right after query")

    // no result beat straight out of reset
    `FGDQ_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

bind functional_graph_distance_query_top fgdq_checker u_fgdq_checker (.*);

// ===== bench/functional_graph_distance_query_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// functional_graph_distance_query_top_tb
// Drives successor loads, table builds and distance queries into the block.
// A local model of the jump-table build predicts every query answer, and
// each output beat is checked against the oldest predicted answer. Both
// stream sides idle in random bursts, and node_count is swept between phases.
// ---------------------------------------------------------------------------
module functional_graph_distance_query_top_tb;
    import fgdq_pkg::*;

    localparam int N_MAX  = DEF_NODES;
    localparam int LEVELS = DEF_LIFT_LEVELS;

    typedef struct packed {
        logic              reachable;
        logic [DIST_W-1:0] distance;
    } answer_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CNT_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [REQ_W-1:0]       i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    functional_graph_distance_query_top dut (.*);

    always #6 i_clk = ~i_clk;

    // graph model state
    int unsigned succ_mem[N_MAX];
    bit          succ_loaded[N_MAX];
    int unsigned jump[LEVELS][N_MAX];
    int unsigned indeg[N_MAX];
    int unsigned peel[N_MAX];
    int unsigned comp_of[N_MAX];
    int unsigned cyc_pos[N_MAX];
    bit          on_cyc[N_MAX];
    int unsigned depth[N_MAX];
    int unsigned cyc_len[N_MAX];
    bit          built;
    int unsigned node_count_reg = 1024;

    answer_t pending_answers[$];
    int      fail_count;
    int      items_sent;
    int      answers_seen;
    int      builds_done;
    bit      no_idle;

    function automatic int unsigned live_nodes();
        int unsigned c;
        c = node_count_reg;
        if (c == 0) c = 1;
        if (c > N_MAX) c = N_MAX;
        return c;
    endfunction

    function automatic int unsigned lift_walk(int unsigned x, int unsigned steps);
        for (int lv = 0; lv < LEVELS; lv++)
            if ((steps >> lv) & 1) x = jump[lv][x];
        return x;
    endfunction

    // Jump tables, in-degree peel, cycle labels, tree depths
    function automatic void build_tables();
        int unsigned n, head, tail, comp, s, v, cur, pos, u;
        n = live_nodes();
        head = 0; tail = 0; comp = 0;
        for (int i = 0; i < N_MAX; i++) begin
            indeg[i] = 0; comp_of[i] = 0; on_cyc[i] = 0; cyc_pos[i] = 0; depth[i] = 0;
        end
        for (int i = 0; i < n; i++) begin
            s = succ_mem[i];
            if (s >= n) s = 0;
            jump[0][i] = s;
            indeg[s]++;
        end
        for (int lv = 1; lv < LEVELS; lv++)
            for (int i = 0; i < n; i++)
                jump[lv][i] = jump[lv-1][jump[lv-1][i]];
        for (int i = 0; i < n; i++)
            if (indeg[i] == 0) peel[tail++] = i;
        while (head < tail) begin
            v = jump[0][peel[head++]];
            indeg[v]--;
            if (indeg[v] == 0 && tail < n) peel[tail++] = v;
        end
        for (int i = 0; i < n; i++) begin
            if (indeg[i] > 0 && !on_cyc[i]) begin
                cur = i; pos = 0;
                while (!on_cyc[cur] && pos < n) begin
                    on_cyc[cur] = 1;
                    cyc_pos[cur] = pos++;
                    comp_of[cur] = comp;
                    cur = jump[0][cur];
                end
                cyc_len[comp] = pos;
                if (comp + 1 < n) comp++;
            end
        end
        while (tail > 0) begin
            u = peel[--tail];
            v = jump[0][u];
            depth[u] = depth[v] + 1;
            comp_of[u] = comp_of[v];
        end
        built = 1;
    endfunction

    function automatic int unsigned ring_gap(int unsigned from, int unsigned to,
                                             int unsigned comp);
        int unsigned len;
        len = cyc_len[comp];
        if (len == 0) return 0;
        return (cyc_pos[to] + len - cyc_pos[from]) % len;
    endfunction

    function automatic answer_t distance_answer(int unsigned a, int unsigned b);
        answer_t     r;
        int unsigned n, d;
        n = live_nodes();
        r = '0;
        if (!built || a >= n || b >= n) return r;
        if (comp_of[a] != comp_of[b]) return r;
        if (on_cyc[b]) begin
            if (on_cyc[a]) d = ring_gap(a, b, comp_of[a]);
            else d = depth[a] + ring_gap(lift_walk(a, depth[a]), b, comp_of[a]);
            r.reachable = 1; r.distance = d[DIST_W-1:0];
            return r;
        end
        if (on_cyc[a]) return r;
        if (depth[a] >= depth[b] && lift_walk(a, depth[a] - depth[b]) == b) begin
            d = depth[a] - depth[b];
            r.reachable = 1; r.distance = d[DIST_W-1:0];
        end
        return r;
    endfunction

    // One beat on the request stream; model updated at acceptance
    task automatic send_request(logic [REQ_W-1:0] kind, int unsigned a, int unsigned b);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {4'd0, b[9:0], a[9:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        case (kind)
            REQ_LOAD: begin
                succ_mem[a[9:0]] = b[9:0];
                succ_loaded[a[9:0]] = 1;
                built = 0;
            end
            REQ_BUILD: begin
                build_tables();
                builds_done++;
            end
            REQ_QUERY: pending_answers.push_back(distance_answer(a[9:0], b[9:0]));
            default: ;
        endcase
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic go_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register write only once the block has drained, including a trailing build
    task automatic write_node_count(int unsigned value);
        go_idle();
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (40 * live_nodes() + 200) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_count_reg = value[CNT_W-1:0];
        built = 0;
    endtask

    task automatic build_graph();
        int unsigned n;
        n = live_nodes();
        for (int i = 0; i < n; i++)
            if (!succ_loaded[i]) send_request(REQ_LOAD, i, 0);
        send_request(REQ_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    // Output beats: ready in random stall bursts, compare against oldest answer
    int stall_left;
    always @(posedge i_clk) begin
        if (no_idle || !i_rst_n) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 16) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        answer_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                $error("answer beat with nothing outstanding: tdata=%h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_m_axis_tdata[0] !== want.reachable) begin
                    $error("reachable: expected %0d, got %0d", want.reachable,
                           o_m_axis_tdata[0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[10:1] !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance,
                           o_m_axis_tdata[10:1]);
                    fail_count++;
                end
            end
        end
    end

    // Full 1024-node ring: longest distances, query before build
    task automatic test_full_ring();
        for (int i = 0; i < N_MAX; i++) send_request(REQ_LOAD, i, (i + 1) % N_MAX);
        send_request(REQ_QUERY, 0, 1);
        build_graph();
        send_request(REQ_QUERY, 0, 1023);
        send_request(REQ_QUERY, 1023, 0);
        send_request(REQ_QUERY, 512, 512);
        send_request(REQ_QUERY, 1023, 1022);
    endtask

    // Count extremes, config clearing the built flag, ignored kind, stale tables
    task automatic test_count_extremes();
        write_node_count(0);
        send_request(REQ_QUERY, 0, 0);
        build_graph();
        send_request(REQ_QUERY, 0, 0);
        send_request(REQ_QUERY, 1, 0);
        send_request(REQ_QUERY, 0, 1023);
        send_request(2'd3, 1023, 1023);
        write_node_count(4);
        send_request(REQ_LOAD, 0, 1);
        send_request(REQ_LOAD, 1, 2);
        send_request(REQ_LOAD, 2, 1);
        send_request(REQ_LOAD, 3, 1023);
        build_graph();
        send_request(REQ_QUERY, 3, 2);
        send_request(REQ_QUERY, 0, 2);
        send_request(REQ_QUERY, 2, 0);
        send_request(REQ_QUERY, 3, 0);
        send_request(REQ_LOAD, 3, 3);
        send_request(REQ_QUERY, 3, 3);
        write_node_count(2047);
        build_graph();
        send_request(REQ_QUERY, 3, 0);
        send_request(REQ_QUERY, 1000, 1001);
    endtask

    // Random graphs: mostly small, queries biased toward reachable pairs
    task automatic test_random_graphs(int target);
        int unsigned n, a, b, k, shape, pick;
        while (items_sent < target) begin
            pick = $urandom_range(0, 29);
            if (pick == 0)      write_node_count($urandom_range(0, 1));
            else if (pick == 1) write_node_count($urandom_range(100, 250));
            else                write_node_count($urandom_range(2, 40));
            n = live_nodes();
            shape = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                if (shape == 0)      b = $urandom_range(0, 1023);
                else if (shape == 1) b = (i + 1) % n;
                else if (shape == 2) b = (i == 0) ? 0 : $urandom_range(0, i - 1);
                else                 b = $urandom_range(0, n - 1);
                send_request(REQ_LOAD, i, b);
            end
            if ($urandom_range(0, 7) == 0) send_request(REQ_QUERY, 0, 0);
            build_graph();
            repeat ($urandom_range(8, 24)) begin
                pick = $urandom_range(0, 19);
                a = $urandom_range(0, n - 1);
                if (pick < 11) begin
                    k = $urandom_range(0, 2 * n);
                    b = a;
                    repeat (k) b = jump[0][b];
                end else if (pick < 16) begin
                    b = $urandom_range(0, n - 1);
                end else if (pick < 18) begin
                    a = $urandom_range(0, 1023);
                    b = $urandom_range(0, 1023);
                end else if (pick == 18) begin
                    send_request(2'd3, $urandom_range(0, 1023), $urandom_range(0, 1023));
                    b = $urandom_range(0, n - 1);
                end else begin
                    send_request(REQ_LOAD, a, $urandom_range(0, n - 1));
                    b = $urandom_range(0, n - 1);
                end
                send_request(REQ_QUERY, a, b);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_ring();
        test_count_extremes();
        test_random_graphs(items_sent + 700);
        no_idle = 1;
        test_random_graphs(items_sent + 150);
        go_idle();
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            $error("%0d answers never arrived", pending_answers.size());
            fail_count++;
        end
        $display("Sent %0d request beats with %0d table builds over swept node counts,",
                 items_sent, builds_done);
        $display("and checked %0d distance answers.", answers_seen);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== functional_graph_distance_query_top.f =====
+incdir+hw/rtl
hw/rtl/fgdq_pkg.sv
hw/rtl/fgdq_ram.sv
hw/rtl/functional_graph_distance_query_top.sv
hw/rtl/fgdq_checker.sv
bench/functional_graph_distance_query_top_tb.sv
